>>> rtl/core/sparse_matrix_vector_multiply_unit_macros.svh
// Assertion macros shared by the sparse matrix-vector multiply unit.
// Included by every RTL file that carries concurrent checks; needs no package.
`ifndef SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH
`define SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define SMVM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check that cons holds in the cycle after ante.
`define SMVM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SMVM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SMVM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/smvm_pkg.sv
// Types and constants of the sparse matrix-vector multiply unit.
// No dependencies; used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package smvm_pkg;

  // Field widths fixed by the item format
  localparam int unsigned OP_W       = 2;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned PROD_W     = 2 * VAL_W;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_ACC  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS  = 2'd0,
    CFG_NUM_COLS  = 2'd1,
    CFG_TRANSPOSE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_MUL,
    ST_WB
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic capture;
    logic lookup;
    logic mul;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/smvm_intf.sv
// Channel interfaces of the sparse matrix-vector multiply unit:
// item input, result output and configuration write. Depends on smvm_pkg.
`default_nettype none

interface smvm_item_if;
  logic                                valid;
  logic                                ready;
  logic        [smvm_pkg::OP_W-1:0]    op;
  logic        [smvm_pkg::IDX_W-1:0]   row_index;
  logic        [smvm_pkg::IDX_W-1:0]   col_index;
  logic        [smvm_pkg::IDX_W-1:0]   position;
  logic signed [smvm_pkg::VAL_W-1:0]   value;

  modport source (output valid, op, row_index, col_index, position, value, input ready);
  modport sink   (input valid, op, row_index, col_index, position, value, output ready);
endinterface

interface smvm_result_if;
  logic                                valid;
  logic                                ready;
  logic        [smvm_pkg::IDX_W-1:0]   result_position;
  logic signed [smvm_pkg::SUM_W-1:0]   sum;
  logic                                status;

  modport source (output valid, result_position, sum, status, input ready);
  modport sink   (input valid, result_position, sum, status, output ready);
endinterface

interface smvm_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [smvm_pkg::CFG_IDX_W-1:0]       index;
  logic [smvm_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/smvm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module smvm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_i,
  output      logic [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/smvm_ctrl.sv
// Controller of the sparse matrix-vector multiply unit: clearing pass,
// item sequencing and output stall. Depends on smvm_pkg and the macro header.
`default_nettype none
`include "sparse_matrix_vector_multiply_unit_macros.svh"

module smvm_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire smvm_pkg::dp_status_t   status_i,
  output      smvm_pkg::ctrl_cmd_t    cmd_o
);

  smvm_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smvm_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smvm_pkg::ST_CLEAR: begin
        if (status_i.clear_last) state_d = smvm_pkg::ST_IDLE;
      end
      smvm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = smvm_pkg::ST_LOOKUP;
      end
      smvm_pkg::ST_LOOKUP: state_d = smvm_pkg::ST_MUL;
      smvm_pkg::ST_MUL:    state_d = smvm_pkg::ST_WB;
      smvm_pkg::ST_WB: begin
        if (status_i.out_free) state_d = smvm_pkg::ST_IDLE;
      end
      default: state_d = smvm_pkg::ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      smvm_pkg::ST_CLEAR: cmd_o.clear = 1'b1;
      smvm_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      smvm_pkg::ST_LOOKUP: cmd_o.lookup = 1'b1;
      smvm_pkg::ST_MUL:    cmd_o.mul    = 1'b1;
      smvm_pkg::ST_WB:     cmd_o.commit = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  `SMVM_ASSERT_IMP(a_item_reaches_wb, clk_i, rst_ni, in_valid_i && in_ready_o,
    ##3 (state_q == smvm_pkg::ST_WB), "accepted item did not reach write-back")
  `SMVM_ASSERT_NXT(a_clear_once, clk_i, rst_ni, state_q != smvm_pkg::ST_CLEAR,
    state_q != smvm_pkg::ST_CLEAR, "clearing pass restarted")
  `SMVM_ASSERT_NXT(a_wb_holds, clk_i, rst_ni,
    (state_q == smvm_pkg::ST_WB) && !status_i.out_free,
    (state_q == smvm_pkg::ST_WB), "write-back left while output blocked")

endmodule

`default_nettype wire

>>> rtl/core/smvm_dpath.sv
// Datapath of the sparse matrix-vector multiply unit: configuration
// registers, vector and result stores, multiplier, accumulator and output
// register. Depends on smvm_pkg, smvm_intf, smvm_ram and the macro header.
`default_nettype none
`include "sparse_matrix_vector_multiply_unit_macros.svh"

module smvm_dpath #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire smvm_pkg::ctrl_cmd_t             cmd_i,
  output      smvm_pkg::dp_status_t            status_o,
  input  wire logic [smvm_pkg::OP_W-1:0]       op_i,
  input  wire logic [smvm_pkg::IDX_W-1:0]      row_index_i,
  input  wire logic [smvm_pkg::IDX_W-1:0]      col_index_i,
  input  wire logic [smvm_pkg::IDX_W-1:0]      position_i,
  input  wire logic [smvm_pkg::VAL_W-1:0]      value_i,
  smvm_result_if.source                        out_o,
  smvm_cfg_if.sink                             cfg_i
);

  localparam int unsigned AW      = $clog2(MAX_DIM);
  localparam int unsigned IDX_W   = smvm_pkg::IDX_W;
  localparam int unsigned DIM_W   = smvm_pkg::DIM_W;
  localparam int unsigned VAL_W   = smvm_pkg::VAL_W;
  localparam int unsigned PROD_W  = smvm_pkg::PROD_W;
  localparam int unsigned SUM_W   = smvm_pkg::SUM_W;

  // Configuration registers
  logic [DIM_W-1:0] num_rows_q, num_cols_q;
  logic             transpose_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q  <= smvm_pkg::DIM_RESET;
      num_cols_q  <= smvm_pkg::DIM_RESET;
      transpose_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (smvm_pkg::cfg_idx_e'(cfg_i.index))
        smvm_pkg::CFG_NUM_ROWS:  num_rows_q  <= cfg_i.data;
        smvm_pkg::CFG_NUM_COLS:  num_cols_q  <= cfg_i.data;
        smvm_pkg::CFG_TRANSPOSE: transpose_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Index below the configured size and below the store depth
  function automatic logic idx_ok(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] lim);
    idx_ok = (DIM_W'(idx) < lim) && (32'(idx) < 32'(MAX_DIM));
  endfunction

  // Decode the item at transfer: range check and store addresses
  logic          row_ok, col_ok, load_ok, read_ok, err_d;
  logic [AW-1:0] vec_addr_d, res_addr_d;

  always_comb begin
    row_ok     = idx_ok(row_index_i, num_rows_q);
    col_ok     = idx_ok(col_index_i, num_cols_q);
    load_ok    = transpose_q ? idx_ok(position_i, num_rows_q)
                             : idx_ok(position_i, num_cols_q);
    read_ok    = transpose_q ? idx_ok(position_i, num_cols_q)
                             : idx_ok(position_i, num_rows_q);
    vec_addr_d = AW'(position_i);
    res_addr_d = AW'(position_i);
    case (smvm_pkg::op_e'(op_i))
      smvm_pkg::OP_LOAD: err_d = !load_ok;
      smvm_pkg::OP_ACC: begin
        err_d      = !(row_ok && col_ok);
        vec_addr_d = transpose_q ? AW'(row_index_i) : AW'(col_index_i);
        res_addr_d = transpose_q ? AW'(col_index_i) : AW'(row_index_i);
      end
      smvm_pkg::OP_READ: err_d = !read_ok;
      default: err_d = 1'b1;
    endcase
  end

  // Item registers
  logic [smvm_pkg::OP_W-1:0] op_q;
  logic [IDX_W-1:0]          pos_q;
  logic [VAL_W-1:0]          val_q;
  logic                      err_q;
  logic [AW-1:0]             vec_addr_q, res_addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= op_i;
      pos_q      <= position_i;
      val_q      <= value_i;
      err_q      <= err_d;
      vec_addr_q <= vec_addr_d;
      res_addr_q <= res_addr_d;
    end
  end

  logic is_load, is_acc, is_read;
  assign is_load = (op_q == smvm_pkg::OP_LOAD);
  assign is_acc  = (op_q == smvm_pkg::OP_ACC);
  assign is_read = (op_q == smvm_pkg::OP_READ);

  // Clearing sweep counter
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  assign status_o.clear_last = (clr_cnt_q == AW'(MAX_DIM - 1));

  // Stores
  logic [VAL_W-1:0] vec_rdata, vec_wdata;
  logic [SUM_W-1:0] res_rdata, res_wdata, acc_sum;
  logic [AW-1:0]    vec_waddr, res_waddr;
  logic             vec_we, res_we;
  logic [PROD_W-1:0] prod_q;

  assign acc_sum = res_rdata + {{(SUM_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // Write ports: zero during the sweep, else commit of a valid item
  always_comb begin
    if (cmd_i.clear) begin
      vec_we    = 1'b1;
      vec_waddr = clr_cnt_q;
      vec_wdata = '0;
      res_we    = 1'b1;
      res_waddr = clr_cnt_q;
      res_wdata = '0;
    end else begin
      vec_we    = cmd_i.commit && is_load && !err_q;
      vec_waddr = vec_addr_q;
      vec_wdata = val_q;
      res_we    = cmd_i.commit && (is_acc || is_read) && !err_q;
      res_waddr = res_addr_q;
      res_wdata = is_acc ? acc_sum : '0;
    end
  end

  smvm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DIM)) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (vec_waddr),
    .wdata_i (vec_wdata),
    .re_i    (cmd_i.lookup),
    .raddr_i (vec_addr_q),
    .rdata_o (vec_rdata)
  );

  smvm_ram #(.WIDTH(SUM_W), .DEPTH(MAX_DIM)) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (res_waddr),
    .wdata_i (res_wdata),
    .re_i    (cmd_i.lookup),
    .raddr_i (res_addr_q),
    .rdata_o (res_rdata)
  );

  // Multiply matrix element by vector entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= PROD_W'($signed(val_q) * $signed(vec_rdata));
    end
  end

  // Output register
  logic             out_valid_q;
  logic [IDX_W-1:0] out_pos_q;
  logic [SUM_W-1:0] out_sum_q;
  logic             out_status_q;

  assign status_o.out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_pos_q    <= is_read ? pos_q : '0;
      out_sum_q    <= (is_read && !err_q) ? res_rdata : '0;
      out_status_q <= err_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.result_position = out_pos_q;
  assign out_o.sum             = out_sum_q;
  assign out_o.status          = out_status_q;

  `SMVM_ASSERT_NXT(a_commit_loads_out, clk_i, rst_ni, cmd_i.commit, out_valid_q,
    "commit did not load the output register")
  `SMVM_ASSERT_NXT(a_clr_cnt_holds, clk_i, rst_ni, !cmd_i.clear, $stable(clr_cnt_q),
    "sweep counter moved outside the clearing pass")
  `SMVM_ASSERT_IMP(a_err_sum_zero, clk_i, rst_ni, out_valid_q && out_status_q,
    out_sum_q == '0, "error result carries a nonzero sum")

endmodule

`default_nettype wire

>>> rtl/core/sparse_matrix_vector_multiply_unit.sv
// Top level of the sparse matrix-vector multiply unit.
// Depends on smvm_pkg, smvm_intf, smvm_ctrl and smvm_dpath.
`default_nettype none

// Streams COO matrix elements against a stored dense vector and accumulates
// 48-bit wrapping sums per result entry (row in normal mode, column in
// transpose mode). Each item passes from transfer through store lookup,
// multiply and write-back to the output register; the next item is taken
// only once the current one is written back, as each store has a single
// read and a single write port. A result that waits on the output register
// holds write-back of the following item, not its transfer. After reset both
// stores are zeroed by a clearing pass over all MAX_DIM entries during which
// no item is taken; configuration writes are taken at any time.
module sparse_matrix_vector_multiply_unit #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  smvm_item_if.sink       in_ch_i,
  smvm_result_if.source   out_ch_o,
  smvm_cfg_if.sink        cfg_i
);

  smvm_pkg::ctrl_cmd_t  cmd;
  smvm_pkg::dp_status_t status;
  logic                 in_ready;

  assign in_ch_i.ready = in_ready;

  // Sequencer
  smvm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Stores and arithmetic
  smvm_dpath #(.MAX_DIM(MAX_DIM)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .op_i        (in_ch_i.op),
    .row_index_i (in_ch_i.row_index),
    .col_index_i (in_ch_i.col_index),
    .position_i  (in_ch_i.position),
    .value_i     (in_ch_i.value),
    .out_o       (out_ch_o),
    .cfg_i       (cfg_i)
  );

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for sparse_matrix_vector_multiply_unit: streams COO elements,
// vector loads and result reads, and checks every result against a tracked copy of both stores.
// Needs smvm_pkg, the smvm channel interfaces and the unit's RTL.

module testbench;
  import smvm_pkg::*;

  localparam int unsigned MAX_DIM      = 1024;
  localparam int unsigned PHASE_ITEMS  = 110;
  localparam int unsigned SETTLE_LEN   = 8;
  localparam int unsigned N_PHASES     = 10;
  localparam logic [OP_W-1:0]      OP_UNDEFINED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;

  // Sizes and mode per random phase; zero and oversized sizes included
  localparam int unsigned PHASE_ROWS [N_PHASES] = '{1024, 8, 8, 1, 0, 2047, 12, 1024, 3, 16};
  localparam int unsigned PHASE_COLS [N_PHASES] = '{1024, 8, 8, 1, 6, 5, 1500, 1024, 0, 16};
  localparam int unsigned PHASE_TR   [N_PHASES] = '{0, 0, 1, 0, 0, 1, 0, 1, 1, 0};

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic [IDX_W-1:0] position;
    logic [VAL_W-1:0] value;
  } coo_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_position;
    logic [SUM_W-1:0] sum;
    logic             status;
  } entry_result_t;

  // Tracks the dense vector, the accumulated sums and the sizes, and queues
  // the entry each accepted item should produce.
  class coo_product_tracker;
    logic [VAL_W-1:0] dense_vector [MAX_DIM];
    logic [SUM_W-1:0] acc_sums [MAX_DIM];
    logic [DIM_W-1:0] num_rows;
    logic [DIM_W-1:0] num_cols;
    logic             transpose;
    entry_result_t    expected_q [$];
    int unsigned      fail_count;

    function new();
      foreach (dense_vector[i]) dense_vector[i] = '0;
      foreach (acc_sums[i]) acc_sums[i] = '0;
      num_rows   = DIM_RESET;
      num_cols   = DIM_RESET;
      transpose  = 1'b0;
      fail_count = 0;
    endfunction

    function int unsigned rows();
      return (num_rows > MAX_DIM) ? MAX_DIM : num_rows;
    endfunction

    function int unsigned cols();
      return (num_cols > MAX_DIM) ? MAX_DIM : num_cols;
    endfunction

    function int unsigned vec_len();
      return transpose ? rows() : cols();
    endfunction

    function int unsigned res_len();
      return transpose ? cols() : rows();
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_NUM_ROWS:  num_rows = data;
        CFG_NUM_COLS:  num_cols = data;
        CFG_TRANSPOSE: transpose = data[0];
        default: ;
      endcase
    endfunction

    // Apply one accepted item to the stores and queue its entry
    function void take_element(coo_item_t it);
      entry_result_t            exp_r;
      logic [IDX_W-1:0]         vec_idx;
      logic [IDX_W-1:0]         sum_idx;
      logic signed [PROD_W-1:0] product;
      exp_r = '0;
      case (it.op)
        OP_LOAD: begin
          if (it.position < vec_len()) dense_vector[it.position] = it.value;
          else exp_r.status = 1'b1;
        end
        OP_ACC: begin
          if (it.row_index < rows() && it.col_index < cols()) begin
            vec_idx = transpose ? it.row_index : it.col_index;
            sum_idx = transpose ? it.col_index : it.row_index;
            product = $signed(it.value) * $signed(dense_vector[vec_idx]);
            acc_sums[sum_idx] = acc_sums[sum_idx] +
                                {{(SUM_W-PROD_W){product[PROD_W-1]}}, product};
          end else begin
            exp_r.status = 1'b1;
          end
        end
        OP_READ: begin
          exp_r.result_position = it.position;
          if (it.position < res_len()) begin
            exp_r.sum = acc_sums[it.position];
            acc_sums[it.position] = '0;
          end else begin
            exp_r.status = 1'b1;
          end
        end
        default: exp_r.status = 1'b1;
      endcase
      expected_q = {expected_q, exp_r};
    endfunction

    // Compare one result transfer with the oldest queued entry
    function void match_result(entry_result_t got);
      entry_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transfer: position %0d sum %0d status %0d",
                 $time, got.result_position, $signed(got.sum), got.status);
        fail_count++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.result_position !== exp_r.result_position) begin
        $display("%0t: result_position expected %0d actual %0d",
                 $time, exp_r.result_position, got.result_position);
        fail_count++;
      end
      if (got.sum !== exp_r.sum) begin
        $display("%0t: sum expected %0d actual %0d",
                 $time, $signed(exp_r.sum), $signed(got.sum));
        fail_count++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        fail_count++;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   no_gaps = 1'b0;
  int unsigned stall_left;
  coo_product_tracker model = new();

  smvm_item_if   in_ch ();
  smvm_result_if out_ch ();
  smvm_cfg_if    cfg_ch ();

  sparse_matrix_vector_multiply_unit #(
    .MAX_DIM(MAX_DIM)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch),
    .cfg_i   (cfg_ch)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Favor a small window and the top end so that entries collide and sums build up
  function automatic logic [IDX_W-1:0] pick_index(int unsigned limit);
    int unsigned r;
    int unsigned span;
    r = $urandom_range(0, 99);
    if (limit == 0 || r < 15) return IDX_W'($urandom);
    span = (limit < 16) ? limit : 16;
    if (r < 65) return IDX_W'($urandom_range(0, span - 1));
    if (r < 85) return IDX_W'(limit - 1 - $urandom_range(0, span - 1));
    return IDX_W'($urandom_range(0, limit - 1));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic coo_item_t elem(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                                     logic [IDX_W-1:0] col, logic [IDX_W-1:0] pos,
                                     logic [VAL_W-1:0] val);
    coo_item_t it;
    it.op        = op;
    it.row_index = row;
    it.col_index = col;
    it.position  = pos;
    it.value     = val;
    return it;
  endfunction

  function automatic coo_item_t random_item(logic [OP_W-1:0] op);
    coo_item_t it;
    it.op        = op;
    it.row_index = pick_index(model.rows());
    it.col_index = pick_index(model.cols());
    it.position  = pick_index((op == OP_LOAD) ? model.vec_len() : model.res_len());
    it.value     = pick_value();
    return it;
  endfunction

  // Hold valid across back-to-back items; drop it only for a gap
  task automatic send_item(input coo_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= it.op;
    in_ch.row_index <= it.row_index;
    in_ch.col_index <= it.col_index;
    in_ch.position  <= it.position;
    in_ch.value     <= it.value;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    model.take_element(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    model.write_reg(idx, data);
  endtask

  task automatic set_shape(input int unsigned rows, input int unsigned cols, input int unsigned tr);
    write_reg(CFG_NUM_ROWS, CFG_DATA_W'(rows));
    write_reg(CFG_NUM_COLS, CFG_DATA_W'(cols));
    write_reg(CFG_TRANSPOSE, CFG_DATA_W'(tr));
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop valid and wait until every queued entry has come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_LEN) @(posedge clk_i);
  endtask

  task automatic run_directed();
    // Extremes in normal mode at the reset sizes
    send_item(elem(OP_LOAD, 10'd0, 10'd0, 10'd0, 16'h8000));
    send_item(elem(OP_LOAD, 10'd0, 10'd0, 10'd1023, 16'h7FFF));
    send_item(elem(OP_LOAD, 10'd0, 10'd0, 10'd5, 16'h0001));
    send_item(elem(OP_ACC, 10'd0, 10'd0, 10'd0, 16'h8000));
    send_item(elem(OP_ACC, 10'd1023, 10'd1023, 10'd0, 16'h7FFF));
    send_item(elem(OP_ACC, 10'd1023, 10'd0, 10'd0, 16'h7FFF));
    send_item(elem(OP_ACC, 10'd7, 10'd5, 10'd0, 16'hFFFF));
    send_item(elem(OP_ACC, 10'd2, 10'd1023, 10'd0, 16'h8000));
    send_item(elem(OP_READ, 10'd0, 10'd0, 10'd0, 16'h0000));
    send_item(elem(OP_READ, 10'd0, 10'd0, 10'd1023, 16'h0000));
    send_item(elem(OP_READ, 10'd0, 10'd0, 10'd7, 16'h0000));
    send_item(elem(OP_READ, 10'd0, 10'd0, 10'd7, 16'h0000));
    send_item(elem(OP_UNDEFINED, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF));
    wait_idle();
    // Switch to transpose with small rows; the sum left in entry 2 must survive
    write_reg(CFG_UNUSED, '1);
    set_shape(4, 600, 1);
    send_item(elem(OP_LOAD, 10'd0, 10'd0, 10'd3, 16'hFFFE));
    send_item(elem(OP_LOAD, 10'd0, 10'd0, 10'd4, 16'h0005));
    send_item(elem(OP_ACC, 10'd3, 10'd2, 10'd0, 16'h0064));
    send_item(elem(OP_ACC, 10'd4, 10'd0, 10'd0, 16'h0001));
    send_item(elem(OP_ACC, 10'd0, 10'd600, 10'd0, 16'h0001));
    send_item(elem(OP_READ, 10'd0, 10'd0, 10'd2, 16'h0000));
    send_item(elem(OP_READ, 10'd0, 10'd0, 10'd600, 16'h0000));
    send_item(elem(OP_READ, 10'd0, 10'd0, 10'd1023, 16'h0000));
    send_item(elem(OP_LOAD, 10'd0, 10'd0, 10'd1023, 16'h1234));
    wait_idle();
  endtask

  // Loads, then elements, then reads, with some stray items in between
  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < count) begin
      no_gaps = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 19) == 0) begin
        send_item(random_item(OP_W'($urandom_range(0, 3))));
        sent++;
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(random_item(OP_LOAD));
        sent += n;
        n = $urandom_range(2, 8);
        repeat (n) send_item(random_item(OP_ACC));
        sent += n;
        n = $urandom_range(1, 3);
        repeat (n) send_item(random_item(OP_READ));
        sent += n;
      end
    end
    no_gaps = 1'b0;
  endtask

  // Check each result transfer and stall the output at random
  initial begin
    entry_result_t got;
    out_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.result_position = out_ch.result_position;
        got.sum             = out_ch.sum;
        got.status          = out_ch.status;
        model.match_result(got);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Main sequence
  initial begin
    in_ch.valid     = 1'b0;
    in_ch.op        = '0;
    in_ch.row_index = '0;
    in_ch.col_index = '0;
    in_ch.position  = '0;
    in_ch.value     = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    for (int p = 0; p < N_PHASES; p++) begin
      set_shape(PHASE_ROWS[p], PHASE_COLS[p], PHASE_TR[p]);
      run_random(PHASE_ITEMS);
      wait_idle();
    end
    if (model.fail_count == 0 && model.pending() == 0) begin
      $display("sparse_matrix_vector_multiply_unit: match");
    end else begin
      $display("sparse_matrix_vector_multiply_unit: mismatch");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("sparse_matrix_vector_multiply_unit: mismatch");
    $finish;
  end

endmodule
